// ----- rtl/lsr_pkg.sv -----
// Shared types and constants for the LIFO stack with reverse.
// Used by lsr_front, lsr_back and lifo_stack_with_reverse; no dependencies.
package lsr_pkg;

  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_POP     = 2'd1,
    OP_PEEK    = 2'd2,
    OP_REVERSE = 2'd3
  } op_t;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // One decoded request on its way from the front to the back
  typedef struct packed {
    op_t                      op;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

endpackage

// ----- rtl/lsr_front.sv -----
// Front end: accepts requests, decodes the operation and holds them in a
// two-entry command queue for the back end. Depends on lsr_pkg.
module lsr_front import lsr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_op,
  input  logic signed [DATA_W-1:0] in_push_value,
  output logic                     cmd_valid,
  input  logic                     cmd_ready,
  output cmd_t                     cmd
);

  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push_q, pop_q;
  cmd_t       in_cmd;

  // Decode the incoming transaction
  always_comb begin
    in_cmd.op    = op_t'(in_op);
    in_cmd.value = in_push_value;
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign push_q    = in_valid && in_ready;
  assign pop_q     = cmd_valid && cmd_ready;

  // Advance queue pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push_q ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop_q ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_q && !pop_q) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop_q && !push_q) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the payload; no reset needed
  always_ff @(posedge clk) begin
    if (push_q) begin
      q_r[wr_ptr_r] <= in_cmd;
    end
  end

endmodule

// ----- rtl/lsr_back.sv -----
// Back end: executes stack commands on a circular entry memory with a
// direction flag, so reverse is a flag flip. Depends on lsr_pkg.
module lsr_back import lsr_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cmd_valid,
  output logic                       cmd_ready,
  input  cmd_t                       cmd,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [DATA_W-1:0]   out_read_value,
  output logic [STATUS_W-1:0]        out_status,
  output logic                       out_is_empty,
  output logic [COUNT_W-1:0]         out_entry_count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rd_data_r;

  state_t                   state_r;
  logic [AW-1:0]            base_r;
  logic [CW-1:0]            count_r, count_nxt;
  logic                     dir_r;
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_value_r;
  logic [STATUS_W-1:0]      out_status_r;
  logic                     out_empty_r;
  logic [COUNT_W-1:0]       out_count_r;

  logic          take;
  logic          load_res;
  logic          is_full, is_empt;
  logic [AW:0]   tail_sum;
  logic [AW-1:0] tail_idx, top_hi, base_inc, base_dec;
  logic [AW-1:0] wr_addr, rd_addr;
  logic          wr_en, rd_en;

  assign cmd_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign take      = cmd_valid && cmd_ready;
  assign is_full   = (count_r == CW'(DEPTH));
  assign is_empt   = (count_r == '0);
  assign load_res  = (state_r == S_READ) || (take && !rd_en);

  // Work out the circular addresses of both ends
  always_comb begin
    tail_sum = {1'b0, base_r} + (AW+1)'(count_r);
    if (tail_sum >= (AW+1)'(DEPTH)) begin
      tail_idx = AW'(tail_sum - (AW+1)'(DEPTH));
    end else begin
      tail_idx = AW'(tail_sum);
    end
    top_hi   = (tail_idx == '0) ? AW'(DEPTH - 1) : tail_idx - AW'(1);
    base_inc = (base_r == AW'(DEPTH - 1)) ? '0 : base_r + AW'(1);
    base_dec = (base_r == '0) ? AW'(DEPTH - 1) : base_r - AW'(1);
    wr_addr  = dir_r ? base_dec : tail_idx;
    rd_addr  = dir_r ? base_r : top_hi;
    wr_en    = take && (cmd.op == OP_PUSH) && !is_full;
    rd_en    = take && ((cmd.op == OP_POP) || (cmd.op == OP_PEEK)) && !is_empt;
  end

  // Next count after the command being taken
  always_comb begin
    count_nxt = count_r;
    if (wr_en) begin
      count_nxt = count_r + CW'(1);
    end else if (rd_en && (cmd.op == OP_POP)) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= cmd.value;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Sequence commands and hold the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      base_r      <= '0;
      count_r     <= '0;
      dir_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // Load a new result, or drop the one just taken
      if (load_res) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (take) begin
            count_r <= count_nxt;
            if (wr_en && dir_r) begin
              base_r <= base_dec;
            end
            if (rd_en && dir_r && (cmd.op == OP_POP)) begin
              base_r <= base_inc;
            end
            if (cmd.op == OP_REVERSE) begin
              dir_r <= ~dir_r;
            end
            if (rd_en) begin
              state_r <= S_READ;
            end else begin
              out_value_r  <= '0;
              out_empty_r  <= (count_nxt == '0);
              out_count_r  <= COUNT_W'(count_nxt);
              if (cmd.op == OP_PUSH) begin
                out_status_r <= is_full ? ST_FULL : ST_OK;
              end else if (cmd.op == OP_REVERSE) begin
                out_status_r <= ST_OK;
              end else begin
                out_status_r <= ST_EMPTY;
              end
            end
          end
        end
        S_READ: begin
          // Result register was freed when this read was issued
          out_value_r  <= rd_data_r;
          out_status_r <= ST_OK;
          out_empty_r  <= is_empt;
          out_count_r  <= COUNT_W'(count_r);
          state_r      <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_value  = out_value_r;
  assign out_status      = out_status_r;
  assign out_is_empty    = out_empty_r;
  assign out_entry_count = out_count_r;

endmodule

// ----- rtl/lifo_stack_with_reverse.sv -----
// LIFO stack of signed 32-bit words with push, pop, peek and reverse.
// Instantiates lsr_front and lsr_back; depends on lsr_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries in_op and in_push_value.
//   Result channel (out_valid/out_ready) returns one result per request:
//   out_read_value, out_status (ok, empty, full), out_is_empty and
//   out_entry_count after the operation.
//   Results: for a push, reverse or failed pop/peek the back end registers
//   the result when it takes the command; a successful pop or peek first
//   goes through the registered read port of the entry memory and the
//   S_READ state.
//   Throughput: one request per cycle for push, reverse and errors while
//   out_ready is high; the back end takes no new request while a pop or
//   peek is in S_READ. Reverse flips the direction of the entry store.
//   A two-entry command queue sits between the front and the back, so
//   requests keep being taken while a result waits on out_ready.
//   Reset empties the stack at once; stored words are not cleared.
//   When the receiver stalls, the result holds and the queue fills, after
//   which in_ready drops.
module lifo_stack_with_reverse import lsr_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_op,
  input  logic signed [DATA_W-1:0] in_push_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_read_value,
  output logic [STATUS_W-1:0]      out_status,
  output logic                     out_is_empty,
  output logic [COUNT_W-1:0]       out_entry_count
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  // Accept and queue transactions
  lsr_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_push_value (in_push_value),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .cmd           (cmd)
  );

  // Execute commands against the stack
  lsr_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd_valid),
    .cmd_ready       (cmd_ready),
    .cmd             (cmd),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_read_value  (out_read_value),
    .out_status      (out_status),
    .out_is_empty    (out_is_empty),
    .out_entry_count (out_entry_count)
  );

  // An empty error leaves the stack empty and reads zero
  a_empty_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY) |-> out_is_empty && (out_read_value == '0))
    else $error("empty error with entries or data");

  // A full refusal never reports an empty stack and reads zero
  a_full_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> !out_is_empty && (out_read_value == '0))
    else $error("full error on empty stack or with data");

  // A command is offered to the back only after something was accepted
  a_cmd_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(cmd_valid) |-> $past(in_valid && in_ready))
    else $error("command appeared without an accepted transaction");

  // A taken reverse presents an ok result on the next cycle
  a_rev: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_valid && cmd_ready && (cmd.op == OP_REVERSE) |=> out_valid && (out_status == ST_OK))
    else $error("reverse did not report ok");

endmodule

// ----- tb/sv/tb_lifo_stack_with_reverse.sv -----
// Self-checking testbench for lifo_stack_with_reverse: push, pop, peek and reverse traffic
// checked against a shadow stack kept in a small scoreboard class.
// Depends on lsr_pkg and the RTL of lifo_stack_with_reverse.
`timescale 1ns / 100ps

module tb_lifo_stack_with_reverse;
  import lsr_pkg::*;

  localparam int STACK_DEPTH  = 64;
  localparam int ITEM_TARGET  = 1850;
  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 10;

  // Shadow stack: predicts each result and checks the block's answers in order
  class lifo_shadow;
    typedef struct {
      logic signed [DATA_W-1:0] read_value;
      logic [STATUS_W-1:0]      status;
      logic                     is_empty;
      logic [COUNT_W-1:0]       entry_count;
    } stack_result_t;

    logic signed [DATA_W-1:0] words[];
    int unsigned              fill;
    int unsigned              capacity;
    stack_result_t            pending_results[$];
    int unsigned              fail_count;

    function new(int unsigned depth);
      capacity   = depth;
      words      = new[depth];
      fill       = 0;
      fail_count = 0;
    endfunction

    // Apply one accepted transaction to the shadow stack and queue its result
    function void note_request(op_t op, logic signed [DATA_W-1:0] value);
      stack_result_t            r;
      logic signed [DATA_W-1:0] t;
      int                       lo;
      int                       hi;
      r.read_value = '0;
      r.status     = ST_OK;
      case (op)
        OP_PUSH: begin
          if (fill >= capacity) begin
            r.status = ST_FULL;
          end else begin
            words[fill] = value;
            fill++;
          end
        end
        OP_POP, OP_PEEK: begin
          if (fill == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.read_value = words[fill-1];
            if (op == OP_POP) fill--;
          end
        end
        default: begin
          lo = 0;
          hi = int'(fill) - 1;
          while (lo < hi) begin
            t         = words[lo];
            words[lo] = words[hi];
            words[hi] = t;
            lo++;
            hi--;
          end
        end
      endcase
      r.is_empty    = (fill == 0);
      r.entry_count = COUNT_W'(fill);
      pending_results.push_back(r);
    endfunction

    function void report(string field, logic [DATA_W-1:0] exp_v, logic [DATA_W-1:0] act_v);
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, exp_v, act_v);
    endfunction

    // Compare one accepted result with the oldest prediction
    function void check_result(logic signed [DATA_W-1:0] read_value,
                               logic [STATUS_W-1:0] status, logic is_empty,
                               logic [COUNT_W-1:0] entry_count);
      stack_result_t e;
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t: result with no request waiting, expected none, got read_value %0h",
                 $time, read_value);
        return;
      end
      e = pending_results.pop_front();
      if (read_value !== e.read_value)   report("read_value", e.read_value, read_value);
      if (status !== e.status)           report("status", e.status, status);
      if (is_empty !== e.is_empty)       report("is_empty", e.is_empty, is_empty);
      if (entry_count !== e.entry_count) report("entry_count", e.entry_count, entry_count);
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [1:0]               in_op;
  logic signed [DATA_W-1:0] in_push_value;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [DATA_W-1:0] out_read_value;
  logic [STATUS_W-1:0]      out_status;
  logic                     out_is_empty;
  logic [COUNT_W-1:0]       out_entry_count;

  lifo_shadow  sb;
  int unsigned items_sent;
  int unsigned burst_left;
  int unsigned idle_cycles;
  bit          no_gaps;
  bit          hold_req;

  lifo_stack_with_reverse #(
    .DEPTH(STACK_DEPTH)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_push_value  (in_push_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .out_is_empty   (out_is_empty),
    .out_entry_count(out_entry_count)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Sample both channels at the rising edge; watch for a stalled run
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_request(op_t'(in_op), in_push_value);
      if (out_valid && out_ready)
        sb.check_result(out_read_value, out_status, out_is_empty, out_entry_count);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("simulation failed");
          $finish;
        end
      end
    end
  end

  // Receiver: drive out_ready from a random pattern redrawn each window, or hold off on request
  initial begin
    int unsigned mode;
    int unsigned window;
    out_ready = 1'b0;
    mode      = 0;
    window    = 0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if (window == 0) mode = $urandom_range(0, 3);
        window = (window + 1) % 32;
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ~out_ready;
          2:       out_ready <= $urandom_range(0, 1);
          default: out_ready <= ($urandom_range(0, 9) != 0);
        endcase
        @(negedge clk);
      end
    end
  end

  function automatic logic signed [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      3:       return '1;
      4:       return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  // Offer one transaction and hold it until accepted; return at the next falling edge
  task automatic send_item(op_t op, logic signed [DATA_W-1:0] value);
    in_valid      <= 1'b1;
    in_op         <= op;
    in_push_value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // Insert a random gap at the end of each burst
  task automatic pace_sender();
    if (no_gaps) return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 10);
    end
  endtask

  task automatic send_paced(op_t op, logic signed [DATA_W-1:0] value);
    send_item(op, value);
    pace_sender();
  endtask

  // Pause the sender until every predicted result has been returned
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending_results.size() != 0);
  endtask

  // Push up to full with some reverses mixed in, then a few refused pushes
  task automatic run_fill();
    int unsigned extra;
    extra = $urandom_range(0, 3);
    while (sb.fill < STACK_DEPTH) begin
      if ($urandom_range(0, 7) == 0) send_paced(OP_REVERSE, pick_word());
      else                           send_paced(OP_PUSH, pick_word());
    end
    repeat (extra) send_paced(OP_PUSH, pick_word());
  endtask

  // Pop down to empty with some peeks, then a few empty errors
  task automatic run_drain();
    int unsigned extra;
    extra = $urandom_range(0, 2);
    while (sb.fill > 0) begin
      if ($urandom_range(0, 5) == 0) send_paced(OP_PEEK, pick_word());
      else                           send_paced(OP_POP, pick_word());
    end
    repeat (extra) send_paced($urandom_range(0, 1) ? OP_POP : OP_PEEK, pick_word());
  endtask

  // Weighted mix of all operations
  task automatic run_mixed(int unsigned n, int unsigned push_pct);
    int unsigned roll;
    repeat (n) begin
      roll = $urandom_range(0, 99);
      if (roll < push_pct)          send_paced(OP_PUSH, pick_word());
      else if (roll < push_pct + 30) send_paced(OP_POP, pick_word());
      else if (roll < push_pct + 45) send_paced(OP_PEEK, pick_word());
      else                           send_paced(OP_REVERSE, pick_word());
    end
  endtask

  // Uniform noise over every operation and value
  task automatic run_noise(int unsigned n);
    repeat (n) send_paced(op_t'($urandom_range(0, 3)), $urandom);
  endtask

  initial begin
    int unsigned seq;
    sb            = new(STACK_DEPTH);
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_op         = OP_PUSH;
    in_push_value = '0;
    items_sent    = 0;
    burst_left    = 0;
    idle_cycles   = 0;
    no_gaps       = 1'b0;
    hold_req      = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: empty errors, one-entry reverse, extreme values, order after reverse
    send_paced(OP_POP, 32'h1234_5678);
    send_paced(OP_PEEK, '0);
    send_paced(OP_REVERSE, '0);
    send_paced(OP_PUSH, 32'h7fff_ffff);
    send_paced(OP_REVERSE, '0);
    send_paced(OP_PEEK, '0);
    send_paced(OP_PUSH, 32'h8000_0000);
    send_paced(OP_PUSH, '0);
    send_paced(OP_PUSH, '1);
    send_paced(OP_PUSH, 32'h5555_aaaa);
    send_paced(OP_REVERSE, '0);
    send_paced(OP_PEEK, '0);
    send_paced(OP_POP, '0);
    send_paced(OP_POP, '0);
    send_paced(OP_REVERSE, '0);
    send_paced(OP_POP, '0);
    send_paced(OP_POP, '0);
    send_paced(OP_POP, '0);
    send_paced(OP_POP, '0);
    send_paced(OP_PEEK, '0);
    wait_drained();

    // Random: well-formed fill and drain runs, mixes and some noise
    seq = 0;
    while (items_sent < ITEM_TARGET) begin
      seq++;
      if (seq == 6 || seq == 30) begin
        // Hold the receiver off while the sender keeps offering
        hold_req = 1'b1;
        no_gaps  = 1'b1;
        run_mixed(60, 50);
        no_gaps  = 1'b0;
        wait_drained();
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2: run_fill();
          3, 4:    run_drain();
          5, 6, 7: run_mixed($urandom_range(8, 40), $urandom_range(20, 50));
          8:       run_mixed($urandom_range(8, 24), 30);
          default: run_noise($urandom_range(4, 16));
        endcase
        if (seq % 7 == 0) wait_drained();
      end
    end

    // Let the last results come back, then report
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.fail_count == 0 && sb.pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
